// ----- hdl/pts_pkg.sv -----
// Package: shared types and constants for the task scheduler.
`default_nettype none
package pts_pkg;
	localparam int TASK_SLOTS_DEF = 16;

	typedef enum logic [1:0] {
		OP_CREATE = 2'd0,
		OP_START  = 2'd1,
		OP_DELAY  = 2'd2,
		OP_TICK   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NO_SLOT = 2'd1,
		ST_NO_TASK = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [7:0]  task_priority;
		logic [15:0] delay_ticks;
	} in_item_t;

	typedef struct packed {
		logic [3:0]  running_task;
		logic        switched;
		logic [3:0]  created_slot;
		logic [1:0]  status;
		logic [15:0] tick_count;
		logic [15:0] switch_count;
	} out_item_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_INS_HEAD,
		S_INS_WALK,
		S_INS_LINK,
		S_TICK_RD,
		S_TICK_DEC,
		S_SCHED,
		S_OUT
	} state_t;
endpackage
`default_nettype wire

// ----- hdl/priority_task_scheduler_with_delays_core.sv -----
// Top level of the priority task scheduler.
// One beat in, one beat out. Each input beat is latched, then dispatched by its operation.
// Start, delay and a create with no free slot go straight on to the schedule step and the
// result beat. A create tries the ready head and, if the new task does not land there, walks
// the ready list one slot per step and links it in. A tick reads and decrements each delayed
// task in turn, and a task that wakes is put into the ready list the same way. The input is
// not ready until the result beat is taken.
`default_nettype none
module priority_task_scheduler_with_delays_core import pts_pkg::*; #(
	parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire in_item_t in_data,
	output logic          out_valid,
	input  wire logic     out_ready,
	output out_item_t     out_data
);
	pts_core_fsm #(.TASK_SLOTS(TASK_SLOTS)) u_core (
		.clk, .arst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data
	);
endmodule
`default_nettype wire

// ----- hdl/pts_core_fsm.sv -----
// Sequencer: walks the ready list and delayed stack one slot per step.
`default_nettype none
module pts_core_fsm import pts_pkg::*; #(
	parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_item_t  in_data,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_item_t      out_data
);
	localparam int IW = $clog2(TASK_SLOTS + 1);
	localparam int SW = $clog2(TASK_SLOTS);
	localparam logic [IW-1:0] NONE = IW'(TASK_SLOTS);

	// slot tables, link values use NONE as end marker
	logic [7:0]    prio_q  [TASK_SLOTS];
	logic [15:0]   delay_q [TASK_SLOTS];
	logic [IW-1:0] rlink_q [TASK_SLOTS];
	logic [IW-1:0] dlink_q [TASK_SLOTS];

	state_t state_q, state_d;
	logic [IW-1:0] rhead_q, dhead_q, used_q, cur_task_q;
	logic          started_q;
	logic [15:0]   ticks_q, sw_cnt_q;
	in_item_t      item_q;
	// insert and walk registers
	logic [IW-1:0] ins_q, walk_q, prev_q, tcur_q, tprev_q, tnext_q;
	logic [7:0]    ins_prio_q;
	logic          in_tick_q, sw_q;
	logic [3:0]    created_q;
	status_t       status_q;

	logic [7:0]    walk_nx_prio;
	logic [IW-1:0] walk_nx;
	assign walk_nx = rlink_q[walk_q[SW-1:0]];
	assign walk_nx_prio = prio_q[walk_nx[SW-1:0]];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:     if (in_valid) state_d = S_DISPATCH;
			S_DISPATCH: begin
				unique case (op_t'(item_q.operation))
					OP_CREATE: state_d = (used_q >= NONE) ? S_SCHED : S_INS_HEAD;
					OP_START:  state_d = S_SCHED;
					OP_DELAY:  state_d = S_SCHED;
					OP_TICK:   state_d = S_TICK_RD;
					default:   state_d = S_SCHED;
				endcase
			end
			S_INS_HEAD: begin
				if (rhead_q == NONE || ins_prio_q < prio_q[rhead_q[SW-1:0]])
					state_d = in_tick_q ? S_TICK_RD : S_SCHED;
				else
					state_d = S_INS_WALK;
			end
			S_INS_WALK: if (walk_nx == NONE || ins_prio_q < walk_nx_prio) state_d = S_INS_LINK;
			S_INS_LINK: state_d = in_tick_q ? S_TICK_RD : S_SCHED;
			S_TICK_RD:  state_d = (tcur_q == NONE) ? S_SCHED : S_TICK_DEC;
			S_TICK_DEC: state_d = (delay_q[tcur_q[SW-1:0]] == 16'd1) ? S_INS_HEAD : S_TICK_RD;
			S_SCHED:    state_d = S_OUT;
			S_OUT:      if (out_ready) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = (state_q == S_IDLE);
		out_valid = (state_q == S_OUT);
		out_data.running_task = (cur_task_q == NONE) ? 4'd0 : 4'(cur_task_q);
		out_data.switched     = sw_q;
		out_data.created_slot = created_q;
		out_data.status       = status_q;
		out_data.tick_count   = ticks_q;
		out_data.switch_count = sw_cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			rhead_q    <= NONE;
			dhead_q    <= NONE;
			used_q     <= '0;
			cur_task_q <= NONE;
			started_q  <= 1'b0;
			ticks_q    <= '0;
			sw_cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						item_q    <= in_data;
						sw_q      <= 1'b0;
						created_q <= '0;
						status_q  <= ST_OK;
						in_tick_q <= 1'b0;
					end
				end
				S_DISPATCH: begin
					unique case (op_t'(item_q.operation))
						OP_CREATE: begin
							if (used_q >= NONE) status_q <= ST_NO_SLOT;
							else begin
								prio_q[used_q[SW-1:0]]  <= item_q.task_priority;
								delay_q[used_q[SW-1:0]] <= '0;
								ins_q      <= used_q;
								ins_prio_q <= item_q.task_priority;
								created_q  <= 4'(used_q);
								used_q     <= used_q + 1'b1;
							end
						end
						OP_START: begin
							if (!started_q) begin
								started_q  <= 1'b1;
								cur_task_q <= rhead_q;
								sw_cnt_q   <= sw_cnt_q + 1'b1;
								sw_q       <= 1'b1;
							end
						end
						OP_DELAY: begin
							if (rhead_q == NONE) status_q <= ST_NO_TASK;
							else begin
								rhead_q <= rlink_q[rhead_q[SW-1:0]];
								delay_q[rhead_q[SW-1:0]] <= (item_q.delay_ticks == 16'd0) ?
									16'd1 : item_q.delay_ticks;
								dlink_q[rhead_q[SW-1:0]] <= dhead_q;
								dhead_q <= rhead_q;
							end
						end
						OP_TICK: begin
							ticks_q   <= ticks_q + 1'b1;
							in_tick_q <= 1'b1;
							tcur_q    <= dhead_q;
							tprev_q   <= NONE;
						end
						default: ;
					endcase
				end
				S_INS_HEAD: begin
					if (rhead_q == NONE) begin
						rhead_q <= ins_q;
						rlink_q[ins_q[SW-1:0]] <= NONE;
					end else if (ins_prio_q < prio_q[rhead_q[SW-1:0]]) begin
						rlink_q[ins_q[SW-1:0]] <= rhead_q;
						rhead_q <= ins_q;
					end else begin
						walk_q <= rhead_q;
					end
				end
				S_INS_WALK: begin
					if (!(walk_nx == NONE || ins_prio_q < walk_nx_prio)) walk_q <= walk_nx;
					prev_q <= walk_q;
				end
				S_INS_LINK: begin
					rlink_q[ins_q[SW-1:0]]  <= rlink_q[prev_q[SW-1:0]];
					rlink_q[prev_q[SW-1:0]] <= ins_q;
				end
				S_TICK_RD: tnext_q <= (tcur_q == NONE) ? NONE : dlink_q[tcur_q[SW-1:0]];
				S_TICK_DEC: begin
					// one decrement per step on the current delayed task
					delay_q[tcur_q[SW-1:0]] <= delay_q[tcur_q[SW-1:0]] - 16'd1;
					if (delay_q[tcur_q[SW-1:0]] == 16'd1) begin
						if (tprev_q == NONE) dhead_q <= tnext_q;
						else dlink_q[tprev_q[SW-1:0]] <= tnext_q;
						ins_q      <= tcur_q;
						ins_prio_q <= prio_q[tcur_q[SW-1:0]];
					end else begin
						tprev_q <= tcur_q;
					end
					tcur_q <= tnext_q;
				end
				S_SCHED: begin
					if (started_q && !sw_q && rhead_q != cur_task_q) begin
						cur_task_q <= rhead_q;
						sw_cnt_q   <= sw_cnt_q + 1'b1;
						sw_q       <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- hdl/pts_checker.sv -----
// Port checker for the task scheduler, bound to the top level.
`default_nettype none
module pts_checker import pts_pkg::*; (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      in_valid,
	input wire logic      in_ready,
	input wire logic      out_valid,
	input wire logic      out_ready,
	input wire out_item_t out_data
);
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input ready while result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("result dropped");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.status <= ST_NO_TASK) else $error("bad status");
	a_created: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_OK |-> out_data.created_slot == 4'd0)
		else $error("slot on failure");
endmodule
bind priority_task_scheduler_with_delays_core pts_checker u_chk (
	.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);
`default_nettype wire
